### design/smrc_pkg.sv
package smrc_pkg;

	localparam int VALUE_W      = 31;
	localparam int COUNT_W      = 11;
	localparam int CAPACITY_DEF = 1024;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Word walking down the cell row.
	typedef struct packed {
		logic                      act;    // slot holds a word
		logic                      ins;    // insert that will be stored
		logic                      drop;   // insert that found the store full
		logic                      found;  // first cell above the value has been passed
		logic signed [VALUE_W-1:0] value;  // inserted value or query threshold
		logic signed [VALUE_W-1:0] carry;  // value displaced by the insert
	} tok_t;

endpackage

### design/smrc_cell.sv
module smrc_cell
	import smrc_pkg::*;
#(
	parameter int CNT_W = COUNT_W,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  tok_t             tok_in,
	input  logic [CNT_W-1:0] cnt_in,
	input  logic [CNT_W-1:0] pos_in,
	output tok_t             tok_out,
	output logic [CNT_W-1:0] cnt_out,
	output logic [CNT_W-1:0] pos_out
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] val_d;
	logic                      wr;
	logic                      occ;
	logic                      le;
	tok_t                      tok_d;
	tok_t                      tok_q;
	logic                      act_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          pos_q;
	logic [CNT_W-1:0]          pos_d;

	// The count seen by this word when it entered tells which cells are filled.
	assign occ = IDX_C < cnt_in;
	assign le  = val_q <= tok_in.value;

	always_comb begin
		tok_d = tok_in;
		pos_d = pos_in;
		val_d = val_q;
		wr    = 1'b0;
		if (tok_in.act) begin
			if (!tok_in.found && (!occ || !le)) begin
				// First cell holding a larger value, or the first empty one.
				tok_d.found = 1'b1;
				pos_d       = IDX_C;
				if (tok_in.ins) begin
					wr          = 1'b1;
					val_d       = tok_in.value;
					tok_d.carry = val_q;
				end
			end else if (tok_in.found && tok_in.ins && IDX_C <= cnt_in) begin
				// Behind the insert point every filled cell moves up by one.
				wr          = 1'b1;
				val_d       = tok_in.carry;
				tok_d.carry = val_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (adv) begin
			act_q <= tok_d.act;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_d;
			cnt_q <= cnt_in;
			pos_q <= pos_d;
		end
		if (adv && wr) begin
			val_q <= val_d;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.act = act_q;
	end

	assign cnt_out = cnt_q;
	assign pos_out = pos_q;

endmodule

### design/sorted_multiset_rank_counter.sv
// Channel   Valid      Stall      Word
// input     valid      stall      kind, value
// result    res_valid  res_stall  count, dropped
//
// A word walks the row of CAPACITY cells one cell per cycle while no result stall holds the row;
// a new word can enter every such cycle, and its result is registered after the last cell.
// Reset clears the word slots and the stored count; cell contents are not cleared.
// A stalled result freezes the whole row, and the input is stalled in the same cycle.
module sorted_multiset_rank_counter
	import smrc_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      stall,
	input  logic                      kind,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [COUNT_W-1:0]        count,
	output logic                      dropped
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic          adv;
	logic          acc;
	logic          full;
	logic [CW-1:0] cnt_q;
	tok_t          tok_head;
	tok_t          tok_w [CAPACITY+1];
	logic [CW-1:0] cnt_w [CAPACITY+1];
	logic [CW-1:0] pos_w [CAPACITY+1];
	tok_t          last;
	logic [CW-1:0] rank;
	logic [CW-1:0] res;
	logic          res_valid_q;
	logic [COUNT_W-1:0] count_q;
	logic          dropped_q;

	assign adv   = !res_valid_q || !res_stall;
	assign stall = !adv;
	assign acc   = valid && adv;
	assign full  = cnt_q >= CAP_C;

	// Count of values admitted so far; later words see earlier inserts through it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc && kind == KIND_INSERT && !full) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_comb begin
		tok_head.act   = acc;
		tok_head.ins   = kind == KIND_INSERT && !full;
		tok_head.drop  = kind == KIND_INSERT && full;
		tok_head.found = 1'b0;
		tok_head.value = value;
		tok_head.carry = value;
	end

	assign tok_w[0] = tok_head;
	assign cnt_w[0] = cnt_q;
	assign pos_w[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smrc_cell #(
			.CNT_W (CW),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok_w[i]),
			.cnt_in  (cnt_w[i]),
			.pos_in  (pos_w[i]),
			.tok_out (tok_w[i+1]),
			.cnt_out (cnt_w[i+1]),
			.pos_out (pos_w[i+1])
		);
	end

	assign last = tok_w[CAPACITY];
	// A word that never met a larger value is ranked behind every stored one.
	assign rank = last.found ? pos_w[CAPACITY] : cnt_w[CAPACITY];

	always_comb begin
		priority if (last.drop) begin
			res = cnt_w[CAPACITY];
		end else if (last.ins) begin
			res = cnt_w[CAPACITY] + CW'(1);
		end else begin
			res = rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= last.act;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last.act) begin
			count_q   <= COUNT_W'(res);
			dropped_q <= last.drop;
		end
	end

	assign res_valid = res_valid_q;
	assign count     = count_q;
	assign dropped   = dropped_q;

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && dropped_q |-> count_q == COUNT_W'(CAPACITY))
		else $error("dropped insert reports a count other than the capacity");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("stored count exceeds the capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && kind == KIND_INSERT && !full |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("accepted insert did not advance the stored count");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		last.act |-> rank <= cnt_w[CAPACITY])
		else $error("rank exceeds the count seen by the word");

endmodule
